/* sv/knn_pkg.sv */
package knn_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_LIST_DEF   = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int PC_W    = 11;
    localparam int LL_W    = 5;
    localparam int IDX_W   = 10;
    localparam int XY_W    = 16;
    localparam int RANK_W  = 4;
    localparam int DSQ_W   = 33;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 11;

    localparam logic [PC_W-1:0] POINT_COUNT_RST = PC_W'(3);
    localparam logic [LL_W-1:0] LIST_LEN_RST    = LL_W'(8);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CFG_A_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_LIST_LEN    = 1'b1;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] point_index;
        logic [XY_W-1:0]  x_coord;
        logic [XY_W-1:0]  y_coord;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  neighbor_index;
        logic [RANK_W-1:0] rank;
        logic [DSQ_W-1:0]  dist_sq;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [CFG_A_W-1:0] index;
        logic [CFG_D_W-1:0] value;
    } t_cfg_word;

endpackage

/* sv/knn_if.sv */
interface knn_in_if import knn_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface knn_out_if import knn_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface knn_cfg_if import knn_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/knn_ram.sv */
module knn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/k_nearest_neighbor_lists.sv */
// Load: one word per cycle while idle, no result.
// Query: a scan through the point memory read port (one point per cycle, 4-stage
// distance pipeline), then one result word per neighbor (list_len capped at MAX_LIST
// and point_count - 1), one per cycle while the output is ready.
// The next input word is taken once the last result word of a query has been taken.
// Reset: control state cleared, point_count = 3, list_len = 8; point memory not cleared.
module k_nearest_neighbor_lists import knn_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_LIST   = MAX_LIST_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    knn_in_if.sink     i_in,
    knn_out_if.source  o_out,
    knn_cfg_if.sink    i_cfg
);

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = COORD_BITS;
    localparam int DW   = 2 * CW + 1;
    localparam int CNTW = ($clog2(MAX_POINTS + 1) > PC_W) ? $clog2(MAX_POINTS + 1) : PC_W;
    localparam int KW   = $clog2(MAX_LIST + 1);
    localparam int RW   = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_QREAD, S_QLATCH, S_SCAN, S_DRAIN, S_OUT
    } t_state;

    t_state r_state;

    logic [PC_W-1:0] r_point_count;
    logic [LL_W-1:0] r_list_len;

    logic [AW-1:0]   r_qi;
    logic [CNTW-1:0] r_n;
    logic [KW-1:0]   r_k;
    logic [CNTW-1:0] r_b;
    logic [RW-1:0]   r_rank;

    logic [2*CW-1:0] r_qp;
    logic            r_rd_v, r_v2, r_v3, r_v4;
    logic [AW-1:0]   r_rd_idx, r_i2, r_i3, r_i4;
    logic [CW-1:0]   r_dx, r_dy;
    logic [2*CW-1:0] r_px, r_py;
    logic [DW-1:0]   r_sum;

    logic [DW-1:0]   r_cell_d [MAX_LIST];
    logic [AW-1:0]   r_cell_i [MAX_LIST];

    logic            in_acc, out_acc, cfg_acc, out_last, query_go;
    logic [CNTW-1:0] n_eff, qi_ext, k_eff;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [2*CW-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0]   rx, ry, qx, qy;
    logic [MAX_LIST-1:0] lt;

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // effective count and list length for a query arriving now
    always_comb begin
        n_eff = CNTW'(r_point_count);
        if (n_eff > CNTW'(MAX_POINTS)) begin
            n_eff = CNTW'(MAX_POINTS);
        end
        qi_ext = CNTW'(i_in.data.point_index);
        k_eff  = CNTW'(r_list_len);
        if (k_eff > CNTW'(MAX_LIST)) begin
            k_eff = CNTW'(MAX_LIST);
        end
        if (k_eff > n_eff - CNTW'(1)) begin
            k_eff = n_eff - CNTW'(1);
        end
    end

    assign query_go = in_acc && (i_in.data.func == FUNC_QUERY) && (qi_ext < n_eff)
                      && (k_eff != '0);

    assign ram_we    = in_acc && (i_in.data.func == FUNC_LOAD)
                       && (CNTW'(i_in.data.point_index) < CNTW'(MAX_POINTS));
    assign ram_wdata = {CW'(i_in.data.y_coord), CW'(i_in.data.x_coord)};
    assign ram_raddr = (r_state == S_SCAN) ? r_b[AW-1:0] : r_qi;

    knn_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.data.point_index)),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
            r_list_len    <= LIST_LEN_RST;
        end else if (cfg_acc) begin
            case (i_cfg.data.index)
                CFG_POINT_COUNT: r_point_count <= i_cfg.data.value[PC_W-1:0];
                CFG_LIST_LEN:    r_list_len    <= i_cfg.data.value[LL_W-1:0];
                default:         ;
            endcase
        end
    end

    assign out_last = (KW'(r_rank) == r_k - KW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_v  <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_qi    <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_b     <= '0;
            r_rank  <= '0;
        end else begin
            r_v2   <= r_rd_v;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_rd_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (query_go) begin
                        r_qi    <= AW'(i_in.data.point_index);
                        r_n     <= n_eff;
                        r_k     <= KW'(k_eff);
                        r_state <= S_QREAD;
                    end
                end
                S_QREAD: begin
                    r_state <= S_QLATCH;
                end
                S_QLATCH: begin
                    r_b     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // the query point itself is never a candidate
                    r_rd_v   <= (r_b[AW-1:0] != r_qi);
                    r_rd_idx <= r_b[AW-1:0];
                    r_b      <= r_b + CNTW'(1);
                    if (r_b == r_n - CNTW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_v && !r_v2 && !r_v3 && !r_v4) begin
                        r_rank  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_rank <= r_rank + RW'(1);
                        if (out_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // distance pipeline
    assign rx = ram_rdata[CW-1:0];
    assign ry = ram_rdata[2*CW-1:CW];
    assign qx = r_qp[CW-1:0];
    assign qy = r_qp[2*CW-1:CW];

    always_ff @(posedge i_clk) begin
        if (r_state == S_QLATCH) begin
            r_qp <= ram_rdata;
        end
        r_dx  <= (rx > qx) ? rx - qx : qx - rx;
        r_dy  <= (ry > qy) ? ry - qy : qy - ry;
        r_i2  <= r_rd_idx;
        r_px  <= r_dx * r_dx;
        r_py  <= r_dy * r_dy;
        r_i3  <= r_i2;
        r_sum <= DW'(r_px) + DW'(r_py);
        r_i4  <= r_i3;
    end

    // sorted list cells: strict compare keeps the lower index first on ties
    always_comb begin
        for (int i = 0; i < MAX_LIST; i++) begin
            lt[i] = (r_sum < r_cell_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_go) begin
            for (int i = 0; i < MAX_LIST; i++) begin
                r_cell_d[i] <= '1;
                r_cell_i[i] <= '0;
            end
        end else if (r_v4) begin
            for (int i = 0; i < MAX_LIST; i++) begin
                if (lt[i]) begin
                    if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
                        r_cell_d[i] <= r_cell_d[(i > 0) ? i - 1 : 0];
                        r_cell_i[i] <= r_cell_i[(i > 0) ? i - 1 : 0];
                    end else begin
                        r_cell_d[i] <= r_sum;
                        r_cell_i[i] <= r_i4;
                    end
                end
            end
        end else if (out_acc) begin
            // head of the list leaves with each word
            for (int i = 0; i < MAX_LIST; i++) begin
                if (i == MAX_LIST - 1) begin
                    r_cell_d[i] <= '1;
                    r_cell_i[i] <= '0;
                end else begin
                    r_cell_d[i] <= r_cell_d[(i < MAX_LIST - 1) ? i + 1 : i];
                    r_cell_i[i] <= r_cell_i[(i < MAX_LIST - 1) ? i + 1 : i];
                end
            end
        end
    end

    assign o_out.valid               = (r_state == S_OUT);
    assign o_out.data.neighbor_index = IDX_W'(r_cell_i[0]);
    assign o_out.data.rank           = RANK_W'(r_rank);
    assign o_out.data.dist_sq        = DSQ_W'(r_cell_d[0]);
    assign o_out.data.last           = out_last;

    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("point memory written outside idle");

    a_out_no_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!r_v2 && !r_v3 && !r_v4))
        else $error("candidate in flight while list drains");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (KW'(r_rank) < r_k))
        else $error("rank beyond list length");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.data.last) |=> (r_state == S_IDLE))
        else $error("query did not end on last word");

endmodule
